// ===== rtl/core/tvsg_pkg.sv =====
`timescale 1ns / 1ps

package tvsg_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_ADDR  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    // Register indexes
    localparam logic [3:0] REG_NOISE   = 4'd6;
    localparam logic [3:0] REG_ENABLE  = 4'd7;
    localparam logic [3:0] REG_VOL_A   = 4'd8;
    localparam logic [3:0] REG_EFINE   = 4'd11;
    localparam logic [3:0] REG_ECOARSE = 4'd12;
    localparam logic [3:0] REG_SHAPE   = 4'd13;
    localparam logic [3:0] REG_PORTA   = 4'd14;
    localparam logic [3:0] REG_PORTB   = 4'd15;

    localparam int NUM_REGS  = 16;
    localparam int NUM_VOICE = 3;

    // Enable register bits for port direction
    localparam int EN_PORTA_BIT = 6;
    localparam int EN_PORTB_BIT = 7;

    // Shape register bits
    localparam int SHAPE_HOLD_BIT   = 0;
    localparam int SHAPE_ALT_BIT    = 1;
    localparam int SHAPE_ATTACK_BIT = 2;
    localparam int SHAPE_CONT_BIT   = 3;

    localparam logic [17:0] LFSR_TAPS = 18'h24000;
    localparam logic [7:0]  PORT_IDLE = 8'hff;
    localparam logic [3:0]  NIB_ONES  = 4'hf;

    localparam int OUT_W = 40;

    typedef logic [NUM_REGS-1:0][7:0] t_regfile;

    typedef struct packed {
        logic       accept;
        t_req       req;
        logic [7:0] data;
        logic [7:0] port_a_in;
        logic [7:0] port_b_in;
    } t_bus_ctrl;

    typedef struct packed {
        logic       tick;
        logic       shape_wr;
        logic [3:0] shape;
    } t_gen_ctrl;

endpackage

// ===== rtl/core/tvsg_regs.sv =====
`timescale 1ns / 1ps

module tvsg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tvsg_pkg::t_bus_ctrl i_bus,
    output tvsg_pkg::t_regfile  o_regs,
    output tvsg_pkg::t_regfile  o_n_regs,
    output logic [3:0]          o_addr,
    output logic [7:0]          o_rd_data,
    output logic [7:0]          o_n_port_a,
    output logic [7:0]          o_n_port_b
);
    import tvsg_pkg::*;

    t_regfile   r_regs, n_regs;
    logic [3:0] r_addr, n_addr;
    logic [7:0] r_port_a, n_port_a;
    logic [7:0] r_port_b, n_port_b;
    logic [7:0] n_rd;

    always_comb begin
        n_regs   = r_regs;
        n_addr   = r_addr;
        n_port_a = r_port_a;
        n_port_b = r_port_b;
        n_rd     = 8'd0;
        if (i_bus.accept) begin
            unique case (i_bus.req)
                REQ_ADDR: begin
                    n_addr = i_bus.data[3:0];
                end
                REQ_WRITE: begin
                    n_regs[r_addr] = i_bus.data;
                    if (r_addr == REG_ENABLE) begin
                        // drive only on a change of direction
                        if (r_regs[REG_ENABLE][EN_PORTA_BIT] != i_bus.data[EN_PORTA_BIT]) begin
                            n_port_a = i_bus.data[EN_PORTA_BIT] ? r_regs[REG_PORTA] : PORT_IDLE;
                        end
                        if (r_regs[REG_ENABLE][EN_PORTB_BIT] != i_bus.data[EN_PORTB_BIT]) begin
                            n_port_b = i_bus.data[EN_PORTB_BIT] ? r_regs[REG_PORTB] : PORT_IDLE;
                        end
                    end else if (r_addr == REG_PORTA) begin
                        if (r_regs[REG_ENABLE][EN_PORTA_BIT]) begin
                            n_port_a = i_bus.data;
                        end
                    end else if (r_addr == REG_PORTB) begin
                        if (r_regs[REG_ENABLE][EN_PORTB_BIT]) begin
                            n_port_b = i_bus.data;
                        end
                    end
                end
                REQ_READ: begin
                    // sample the external port into its register on a read
                    if (r_addr == REG_PORTA) begin
                        n_regs[REG_PORTA] = i_bus.port_a_in;
                    end else if (r_addr == REG_PORTB) begin
                        n_regs[REG_PORTB] = i_bus.port_b_in;
                    end
                    n_rd = n_regs[r_addr];
                end
                REQ_TICK: begin
                    n_rd = 8'd0;
                end
                default: begin
                    n_rd = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs   <= '0;
            r_addr   <= 4'd0;
            r_port_a <= PORT_IDLE;
            r_port_b <= PORT_IDLE;
        end else begin
            r_regs   <= n_regs;
            r_addr   <= n_addr;
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
        end
    end

    assign o_regs     = r_regs;
    assign o_n_regs   = n_regs;
    assign o_addr     = r_addr;
    assign o_rd_data  = n_rd;
    assign o_n_port_a = n_port_a;
    assign o_n_port_b = n_port_b;

endmodule

// ===== rtl/core/tvsg_gen.sv =====
`timescale 1ns / 1ps

module tvsg_gen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tvsg_pkg::t_gen_ctrl i_ctrl,
    input  tvsg_pkg::t_regfile  i_regs,
    output logic [2:0]          o_n_tone_phase,
    output logic                o_n_noise_phase,
    output logic [3:0]          o_n_env_val
);
    import tvsg_pkg::*;

    logic [2:0][11:0] r_tone_cnt, n_tone_cnt;
    logic [2:0]       r_tone_ph, n_tone_ph;
    logic [4:0]       r_noise_cnt, n_noise_cnt;
    logic             r_noise_ph, n_noise_ph;
    logic [16:0]      r_lfsr, n_lfsr;
    logic [15:0]      r_env_cnt, n_env_cnt;
    logic [3:0]       r_env_step, n_env_step;
    logic [3:0]       r_env_inv, n_env_inv;
    logic             r_env_hold, n_env_hold;
    logic             r_env_alt, n_env_alt;
    logic             r_env_holding, n_env_holding;

    logic [2:0][11:0] tone_div;
    logic [2:0][12:0] tone_inc;
    logic [5:0]       noise_inc;
    logic [17:0]      lfsr_x;
    logic [15:0]      env_period;
    logic [16:0]      env_inc;

    always_comb begin
        for (int ch = 0; ch < NUM_VOICE; ch++) begin
            tone_div[ch] = {i_regs[4'(2*ch+1)][3:0], i_regs[4'(2*ch)]};
            tone_inc[ch] = {1'b0, r_tone_cnt[ch]} + 13'd1;
        end
        noise_inc  = {1'b0, r_noise_cnt} + 6'd1;
        lfsr_x     = {1'b0, r_lfsr} ^ (r_lfsr[0] ? LFSR_TAPS : 18'd0);
        env_period = {i_regs[REG_ECOARSE], i_regs[REG_EFINE]};
        env_inc    = {1'b0, r_env_cnt} + 17'd1;
    end

    always_comb begin
        n_tone_cnt    = r_tone_cnt;
        n_tone_ph     = r_tone_ph;
        n_noise_cnt   = r_noise_cnt;
        n_noise_ph    = r_noise_ph;
        n_lfsr        = r_lfsr;
        n_env_cnt     = r_env_cnt;
        n_env_step    = r_env_step;
        n_env_inv     = r_env_inv;
        n_env_hold    = r_env_hold;
        n_env_alt     = r_env_alt;
        n_env_holding = r_env_holding;

        if (i_ctrl.tick) begin
            for (int ch = 0; ch < NUM_VOICE; ch++) begin
                if (tone_inc[ch] >= {1'b0, tone_div[ch]}) begin
                    n_tone_ph[ch]  = ~r_tone_ph[ch];
                    n_tone_cnt[ch] = 12'd0;
                end else begin
                    n_tone_cnt[ch] = tone_inc[ch][11:0];
                end
            end

            if (noise_inc >= {1'b0, i_regs[REG_NOISE][4:0]}) begin
                if (r_lfsr[0] ^ r_lfsr[1]) begin
                    n_noise_ph = ~r_noise_ph;
                end
                n_lfsr      = lfsr_x[17:1];
                n_noise_cnt = 5'd0;
            end else begin
                n_noise_cnt = noise_inc[4:0];
            end

            if (!r_env_holding) begin
                if (env_inc >= {1'b0, env_period}) begin
                    n_env_cnt = 16'd0;
                    if (r_env_step == 4'd0) begin
                        if (r_env_alt) begin
                            n_env_inv = ~r_env_inv;
                        end
                        if (r_env_hold) begin
                            n_env_holding = 1'b1;
                        end else begin
                            n_env_step = NIB_ONES;
                        end
                    end else begin
                        n_env_step = r_env_step - 4'd1;
                    end
                end else begin
                    n_env_cnt = env_inc[15:0];
                end
            end
        end

        // restart the envelope step, leave its divider running
        if (i_ctrl.shape_wr) begin
            n_env_inv = i_ctrl.shape[SHAPE_ATTACK_BIT] ? NIB_ONES : 4'd0;
            if (!i_ctrl.shape[SHAPE_CONT_BIT]) begin
                n_env_hold = 1'b1;
                n_env_alt  = i_ctrl.shape[SHAPE_ATTACK_BIT];
            end else begin
                n_env_hold = i_ctrl.shape[SHAPE_HOLD_BIT];
                n_env_alt  = i_ctrl.shape[SHAPE_ALT_BIT];
            end
            n_env_step    = NIB_ONES;
            n_env_holding = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_cnt    <= '0;
            r_tone_ph     <= 3'd0;
            r_noise_cnt   <= 5'd0;
            r_noise_ph    <= 1'b1;
            r_lfsr        <= 17'd1;
            r_env_cnt     <= 16'd0;
            r_env_step    <= NIB_ONES;
            r_env_inv     <= 4'd0;
            r_env_hold    <= 1'b1;
            r_env_alt     <= 1'b0;
            r_env_holding <= 1'b0;
        end else begin
            r_tone_cnt    <= n_tone_cnt;
            r_tone_ph     <= n_tone_ph;
            r_noise_cnt   <= n_noise_cnt;
            r_noise_ph    <= n_noise_ph;
            r_lfsr        <= n_lfsr;
            r_env_cnt     <= n_env_cnt;
            r_env_step    <= n_env_step;
            r_env_inv     <= n_env_inv;
            r_env_hold    <= n_env_hold;
            r_env_alt     <= n_env_alt;
            r_env_holding <= n_env_holding;
        end
    end

    assign o_n_tone_phase  = n_tone_ph;
    assign o_n_noise_phase = n_noise_ph;
    assign o_n_env_val     = n_env_step ^ n_env_inv;

endmodule

// ===== rtl/core/three_voice_sound_generator_core.sv =====
// Three-voice sound generator with a sixteen-register bus interface.
// Input channel (s_axis): each beat is one item. tuser carries the kind:
// address latch write, data write, data read or one sound clock tick.
// tdata carries the write byte and the two external port values.
// Output channel (m_axis): exactly one result beat per input beat, in order,
// holding the read byte (zero unless a read), the three gated level indexes,
// the three envelope-select flags and the values driven on both ports.
// Levels and flags always reflect the state after the item.
// Latency: the result is presented the cycle after the input beat is taken.
// Throughput: one item per clock; the state update is a single pass from the
// state registers to the result register.
// The block keeps taking beats while the result register is being emptied in
// the same cycle; when the receiver stalls with a result held, s_axis_tready
// drops and both sides hold.
// Synchronous active-low reset: all registers clear to zero, the noise LFSR
// and noise phase to one, envelope step to fifteen with hold set, ports
// read as inputs (255), and the output channel empties.
`timescale 1ns / 1ps

module three_voice_sound_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_in[7:0], port_a_in[15:8], port_b_in[23:16]
    input  logic [23:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], level_a[11:8], level_b[15:12], level_c[19:16],
    // env_sel_a[20], env_sel_b[21], env_sel_c[22], port_a_pins[30:23],
    // port_b_pins[38:31], zero pad[39]
    output logic [39:0] m_axis_tdata
);
    import tvsg_pkg::*;

    logic             accept;
    t_req             req;
    t_bus_ctrl        bus;
    t_gen_ctrl        gen_ctrl;
    t_regfile         regs, n_regs;
    logic [3:0]       addr;
    logic [7:0]       rd_data, n_port_a, n_port_b;
    logic [2:0]       n_tone_ph;
    logic             n_noise_ph;
    logic [3:0]       n_env_val;
    logic [2:0][3:0]  level;
    logic [2:0]       env_sel;
    logic [OUT_W-1:0] n_out;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = t_req'(s_axis_tuser);

    assign bus.accept    = accept;
    assign bus.req       = req;
    assign bus.data      = s_axis_tdata[7:0];
    assign bus.port_a_in = s_axis_tdata[15:8];
    assign bus.port_b_in = s_axis_tdata[23:16];

    assign gen_ctrl.tick     = accept && (req == REQ_TICK);
    assign gen_ctrl.shape_wr = accept && (req == REQ_WRITE) && (addr == REG_SHAPE);
    assign gen_ctrl.shape    = s_axis_tdata[3:0];

    tvsg_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bus      (bus),
        .o_regs     (regs),
        .o_n_regs   (n_regs),
        .o_addr     (addr),
        .o_rd_data  (rd_data),
        .o_n_port_a (n_port_a),
        .o_n_port_b (n_port_b)
    );

    tvsg_gen u_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (gen_ctrl),
        .i_regs          (regs),
        .o_n_tone_phase  (n_tone_ph),
        .o_n_noise_phase (n_noise_ph),
        .o_n_env_val     (n_env_val)
    );

    // mixer: tone and noise gates per voice, volume or envelope level
    always_comb begin
        for (int ch = 0; ch < NUM_VOICE; ch++) begin
            env_sel[ch] = n_regs[REG_VOL_A + 4'(ch)][4];
            if ((n_tone_ph[ch] | n_regs[REG_ENABLE][ch]) &
                (n_noise_ph | n_regs[REG_ENABLE][3+ch])) begin
                level[ch] = env_sel[ch] ? n_env_val : n_regs[REG_VOL_A + 4'(ch)][3:0];
            end else begin
                level[ch] = 4'd0;
            end
        end
        n_out = {1'b0, n_port_b, n_port_a, env_sel, level[2], level[1], level[0], rd_data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // input may only stall while a result is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result register");

    // a read of port A returns the sampled external value
    a_port_a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == REQ_READ && addr == REG_PORTA)
        |=> (m_axis_tdata[7:0] == $past(s_axis_tdata[15:8])))
        else $error("port A read did not return sampled input");

    // a port set as input drives all ones
    a_port_a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !regs[REG_ENABLE][EN_PORTA_BIT]) |-> (m_axis_tdata[30:23] == PORT_IDLE))
        else $error("port A driven while set as input");

    a_port_b_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !regs[REG_ENABLE][EN_PORTB_BIT]) |-> (m_axis_tdata[38:31] == PORT_IDLE))
        else $error("port B driven while set as input");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tvsg_pkg::*;

    localparam logic [3:0] REG_TONE_A  = 4'd0;
    localparam int         ITEM_TARGET = 450;
    localparam int         MID_PAUSE   = 250;
    localparam int         LONG_HOLD   = 80;

    // One result beat, laid out as m_axis_tdata; lvl[0] and sel[0] are channel A
    typedef struct packed {
        logic            pad;
        logic [7:0]      pins_b;
        logic [7:0]      pins_a;
        logic [2:0]      sel;
        logic [2:0][3:0] lvl;
        logic [7:0]      rd;
    } t_voice_out;

    typedef struct {
        t_req       kind;
        logic [7:0] data;
        logic [7:0] pa;
        logic [7:0] pb;
        bit         typed;
        t_voice_out want;
    } t_stim_row;

    localparam t_voice_out NO_WANT = '0;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    three_voice_sound_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Generator state as the block should hold it
    logic [7:0]  psg_regs [NUM_REGS];
    logic [3:0]  sel_reg;
    logic [11:0] tone_cnt [NUM_VOICE];
    logic        tone_ph [NUM_VOICE];
    logic [4:0]  noise_cnt;
    logic        noise_ph;
    logic [16:0] noise_sr;
    logic [15:0] env_cnt;
    logic [3:0]  env_step;
    logic [3:0]  env_inv;
    logic        env_hold;
    logic        env_alt;
    logic        env_frozen;
    logic [7:0]  prev_enable;
    logic [7:0]  drive_a;
    logic [7:0]  drive_b;

    t_voice_out  levels_due [$];
    int          fail_count  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          gap_len     = 0;

    function automatic void model_reset();
        for (int i = 0; i < NUM_REGS; i++) psg_regs[i] = 8'h00;
        for (int ch = 0; ch < NUM_VOICE; ch++) begin
            tone_cnt[ch] = '0;
            tone_ph[ch]  = 1'b0;
        end
        sel_reg     = '0;
        noise_cnt   = '0;
        noise_ph    = 1'b1;
        noise_sr    = 17'd1;
        env_cnt     = '0;
        env_step    = NIB_ONES;
        env_inv     = 4'h0;
        env_hold    = 1'b1;
        env_alt     = 1'b0;
        env_frozen  = 1'b0;
        prev_enable = 8'h00;
        drive_a     = PORT_IDLE;
        drive_b     = PORT_IDLE;
    endfunction

    function automatic void write_reg(logic [3:0] r, logic [7:0] v);
        psg_regs[r] = v;
        case (r)
            REG_ENABLE: begin
                if (prev_enable[EN_PORTA_BIT] != v[EN_PORTA_BIT])
                    drive_a = v[EN_PORTA_BIT] ? psg_regs[REG_PORTA] : PORT_IDLE;
                if (prev_enable[EN_PORTB_BIT] != v[EN_PORTB_BIT])
                    drive_b = v[EN_PORTB_BIT] ? psg_regs[REG_PORTB] : PORT_IDLE;
                prev_enable = v;
            end
            REG_SHAPE: begin
                env_inv = v[SHAPE_ATTACK_BIT] ? NIB_ONES : 4'h0;
                // continue clear: hold at the end, alternate follows attack
                if (!v[SHAPE_CONT_BIT]) begin
                    env_hold = 1'b1;
                    env_alt  = v[SHAPE_ATTACK_BIT];
                end else begin
                    env_hold = v[SHAPE_HOLD_BIT];
                    env_alt  = v[SHAPE_ALT_BIT];
                end
                env_step   = NIB_ONES;
                env_frozen = 1'b0;
            end
            REG_PORTA: if (psg_regs[REG_ENABLE][EN_PORTA_BIT]) drive_a = v;
            REG_PORTB: if (psg_regs[REG_ENABLE][EN_PORTB_BIT]) drive_b = v;
            default: ;
        endcase
    endfunction

    function automatic void advance_tick();
        int          per;
        int          c;
        logic [17:0] sr_next;
        for (int ch = 0; ch < NUM_VOICE; ch++) begin
            per = {psg_regs[REG_TONE_A + 2 * ch + 1][3:0], psg_regs[REG_TONE_A + 2 * ch]};
            c = tone_cnt[ch] + 1;
            if (c >= per) begin
                tone_ph[ch] = ~tone_ph[ch];
                c = 0;
            end
            tone_cnt[ch] = c[11:0];
        end

        per = psg_regs[REG_NOISE][4:0];
        c = noise_cnt + 1;
        if (c >= per) begin
            if (noise_sr[0] ^ noise_sr[1]) noise_ph = ~noise_ph;
            sr_next = {1'b0, noise_sr};
            if (noise_sr[0]) sr_next = sr_next ^ LFSR_TAPS;
            noise_sr = sr_next[17:1];
            c = 0;
        end
        noise_cnt = c[4:0];

        if (!env_frozen) begin
            per = {psg_regs[REG_ECOARSE], psg_regs[REG_EFINE]};
            c = env_cnt + 1;
            if (c >= per) begin
                c = 0;
                if (env_step == 4'h0) begin
                    if (env_alt) env_inv = env_inv ^ NIB_ONES;
                    if (env_hold) env_frozen = 1'b1;
                    else env_step = NIB_ONES;
                end else begin
                    env_step = env_step - 4'd1;
                end
            end
            env_cnt = c[15:0];
        end
    endfunction

    function automatic t_voice_out predict_voice(t_req kind, logic [7:0] d,
                                                 logic [7:0] pa, logic [7:0] pb);
        t_voice_out res;
        logic [3:0] env_val;
        logic [3:0] lvl;
        logic [7:0] en;
        logic [7:0] vreg;
        logic       gate;
        res = '0;
        case (kind)
            REQ_ADDR:  sel_reg = d[3:0];
            REQ_WRITE: write_reg(sel_reg, d);
            REQ_READ: begin
                // port reads sample the pins even when the port drives them
                if (sel_reg == REG_PORTA) psg_regs[REG_PORTA] = pa;
                else if (sel_reg == REG_PORTB) psg_regs[REG_PORTB] = pb;
                res.rd = psg_regs[sel_reg];
            end
            default: advance_tick();
        endcase
        env_val = env_step ^ env_inv;
        en = psg_regs[REG_ENABLE];
        for (int ch = 0; ch < NUM_VOICE; ch++) begin
            gate = (tone_ph[ch] | en[ch]) & (noise_ph | en[3 + ch]);
            vreg = psg_regs[REG_VOL_A + ch];
            lvl = vreg[4] ? env_val : vreg[3:0];
            res.lvl[ch] = gate ? lvl : 4'h0;
            res.sel[ch] = vreg[4];
        end
        res.pins_a = drive_a;
        res.pins_b = drive_b;
        return res;
    endfunction

    // Keep small periods most of the time so the dividers actually fire
    function automatic logic [7:0] pick_value(logic [3:0] r);
        logic [7:0] any_byte;
        any_byte = 8'($urandom);
        if (r < REG_NOISE) begin
            if (r[0]) return ($urandom_range(0, 4) == 0) ? any_byte : 8'h00;
            return ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 6)) : any_byte;
        end
        case (r)
            REG_NOISE, REG_EFINE:
                return ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 3)) : any_byte;
            REG_ECOARSE: return ($urandom_range(0, 6) == 0) ? any_byte : 8'h00;
            default:     return any_byte;
        endcase
    endfunction

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    function automatic void check_field(string name, int got, int want);
        if (got != want)
            note_fail($sformatf("mismatch on %s: expected %0h, got %0h", name, want, got));
    endfunction

    // Present one beat, hold it until taken, then at the end of a burst sometimes idle
    task automatic offer(input t_req kind, input logic [7:0] d, input logic [7:0] pa,
                         input logic [7:0] pb, input bit typed = 1'b0,
                         input t_voice_out want = '0);
        t_voice_out model_out;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pb, pa, d};
        do @(posedge i_clk); while (!s_axis_tready);
        model_out = predict_voice(kind, d, pa, pb);
        levels_due.push_back(typed ? want : model_out);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 19);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (levels_due.size() != 0);
    endtask

    t_stim_row directed_rows [25] = '{
        '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'hff, 8'hff, 3'b000, 12'h000, 8'h00}},
        '{REQ_ADDR,  8'hf7, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'hff, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, 8'h00, 3'b000, 12'h000, 8'h00}},
        '{REQ_ADDR,  8'h08, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h0f, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, 8'h00, 3'b000, 12'h00f, 8'h00}},
        '{REQ_ADDR,  8'h09, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h1f, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h0e, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'ha5, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h0f, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_READ,  8'h00, 8'h00, 8'h5a, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h07, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h3f, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'hff, 8'hff, 3'b010, 12'h0ff, 8'h00}},
        '{REQ_ADDR,  8'h0e, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h3c, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_READ,  8'h00, 8'hc3, 8'h00, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h0d, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h04, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h0c, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_TICK,  8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_TICK,  8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_ADDR,  8'h07, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{REQ_TICK,  8'hff, 8'hff, 8'hff, 1'b0, NO_WANT},
        '{REQ_TICK,  8'h00, 8'h00, 8'h00, 1'b0, NO_WANT}
    };

    initial begin : stimulus
        int         choice;
        logic [3:0] r;
        bit         paused;
        paused = 1'b0;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].pa,
                  directed_rows[i].pb, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= MID_PAUSE) begin
                paused = 1'b1;
                drain_results();
            end
            choice = $urandom_range(0, 99);
            r = 4'($urandom);
            if (choice < 35) begin
                repeat ($urandom_range(1, 12))
                    offer(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (choice < 70) begin
                offer(REQ_ADDR, {4'($urandom), r}, 8'($urandom), 8'($urandom));
                offer(REQ_WRITE, pick_value(r), 8'($urandom), 8'($urandom));
            end else if (choice < 85) begin
                offer(REQ_ADDR, {4'($urandom), r}, 8'($urandom), 8'($urandom));
                offer(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                // stray beat of any kind, outside a latch/access pair
                offer(t_req'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom));
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Receiver: randomly re-chosen stall patterns, plus one long hold-off
    int ready_cyc   = 0;
    int ready_beats = 0;
    int hold_left   = 0;
    int ready_mode  = 0;
    bit long_done   = 1'b0;

    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) ready_beats++;
            ready_cyc++;
            if (ready_cyc % 64 == 0) ready_mode = $urandom_range(0, 3);
            if (!long_done && ready_beats >= 150) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= (ready_cyc % 5 < 3);
                endcase
            end
        end
    end

    t_voice_out seen_beat;
    t_voice_out oldest_due;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat = m_axis_tdata;
            if (levels_due.size() == 0) begin
                note_fail($sformatf("result beat %0h with nothing outstanding", seen_beat));
            end else begin
                oldest_due = levels_due.pop_front();
                check_field("read_data", seen_beat.rd, oldest_due.rd);
                for (int ch = 0; ch < NUM_VOICE; ch++) begin
                    check_field($sformatf("level ch%0d", ch), seen_beat.lvl[ch],
                                oldest_due.lvl[ch]);
                    check_field($sformatf("env_sel ch%0d", ch), seen_beat.sel[ch],
                                oldest_due.sel[ch]);
                end
                check_field("port_a_pins", seen_beat.pins_a, oldest_due.pins_a);
                check_field("port_b_pins", seen_beat.pins_b, oldest_due.pins_b);
                check_field("pad", seen_beat.pad, oldest_due.pad);
            end
        end
    end

endmodule
